// File: rtl/core/rms_block_level_meter_defines.svh
// Assertion macros used by the checker file of the block level meter.
`ifndef RMS_BLOCK_LEVEL_METER_DEFINES_SVH
`define RMS_BLOCK_LEVEL_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("level meter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("level meter check failed");

`endif

// File: rtl/core/rbl_pkg.sv
// Shared constants and types of the block level meter.
`default_nettype none

package rbl_pkg;

	// Default longest block, in counted samples.
	localparam int MAX_BLOCK_DEF = 1024;

	// Fixed field widths.
	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 16;
	localparam int BSAMP_W  = 11;

	// A squared magnitude is at most 2^30.
	localparam int SQ_W = 31;

	// Status of the block queue, seen by both of its neighbors.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/rbl_if.sv
// Handshake channels of the block level meter: sample items in, level items out.
`default_nettype none

interface rbl_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [rbl_pkg::SAMPLE_W-1:0]  sample;
	logic                                 sample_valid;
	logic                                 block_end;

	modport source (output valid, output sample, output sample_valid, output block_end,
		input ready);
	modport sink (input valid, input sample, input sample_valid, input block_end,
		output ready);
endinterface

interface rbl_out_if;
	logic                          valid;
	logic                          ready;
	logic [rbl_pkg::LEVEL_W-1:0]   rms_level;
	logic [rbl_pkg::BSAMP_W-1:0]   block_samples;
	logic                          overflow;

	modport source (output valid, output rms_level, output block_samples, output overflow,
		input ready);
	modport sink (input valid, input rms_level, input block_samples, input overflow,
		output ready);
endinterface

`default_nettype wire

// File: rtl/core/rms_block_level_meter.sv
// Top level of the block RMS level meter.
// Usage:
//   audio: one sample item per cycle while audio.ready is high; sample_valid
//   says whether the sample is counted and block_end closes the block. level:
//   one item per block with the integer RMS level (0 to 32768 for 0.0 to 1.0),
//   the sample count and an overflow flag for blocks longer than MAX_BLOCK samples.
//   Throughput is one sample item per cycle while audio.ready is high. The
//   square and accumulate front end has one register stage; a closing item is
//   registered in stage one, and its block totals enter a two-entry queue as
//   it leaves stage one. The back end then takes the block, runs a restoring
//   division and a bit-by-bit square root, and loads the output register. It
//   works on one block at a time; blocks that come faster fill the queue, and
//   a closing item then waits in stage one while the front end holds
//   audio.ready low.
//   A stalled level receiver keeps its result in the output register; the back
//   end finishes its next block and waits, and the queue then fills.
//   Reset clears the accumulators, the queue and any pending result.
`default_nettype none

module rms_block_level_meter #(
	parameter int MAX_BLOCK = rbl_pkg::MAX_BLOCK_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rbl_in_if.sink      audio,
	rbl_out_if.source   level
);

	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam int SUM_W = rbl_pkg::SQ_W - 1 + CNT_W;
	localparam int Q_W   = SUM_W + CNT_W + 1;

	rbl_pkg::q_stat_t   q_stat;
	logic               push;
	logic               pop;
	logic [SUM_W-1:0]   push_sum;
	logic [CNT_W-1:0]   push_cnt;
	logic               push_ovf;
	logic [Q_W-1:0]     q_out;

	rbl_front #(
		.MAX_BLOCK (MAX_BLOCK),
		.CNT_W     (CNT_W),
		.SUM_W     (SUM_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.audio    (audio),
		.q_stat   (q_stat),
		.push     (push),
		.push_sum (push_sum),
		.push_cnt (push_cnt),
		.push_ovf (push_ovf)
	);

	rbl_queue #(
		.W (Q_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({push_sum, push_cnt, push_ovf}),
		.pop    (pop),
		.dout   (q_out),
		.stat   (q_stat)
	);

	rbl_back #(
		.CNT_W (CNT_W),
		.SUM_W (SUM_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.blk_sum (q_out[Q_W-1:CNT_W+1]),
		.blk_cnt (q_out[CNT_W:1]),
		.blk_ovf (q_out[0]),
		.pop     (pop),
		.level   (level)
	);

endmodule

`default_nettype wire

// File: rtl/core/rbl_front.sv
// Front end: takes sample items, squares them and accumulates each block.
`default_nettype none

module rbl_front #(
	parameter int MAX_BLOCK = rbl_pkg::MAX_BLOCK_DEF,
	parameter int CNT_W     = $clog2(MAX_BLOCK + 1),
	parameter int SUM_W     = rbl_pkg::SQ_W - 1 + CNT_W
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	rbl_in_if.sink                  audio,
	input  wire rbl_pkg::q_stat_t   q_stat,
	output logic                    push,
	output logic [SUM_W-1:0]        push_sum,
	output logic [CNT_W-1:0]        push_cnt,
	output logic                    push_ovf
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK);

	logic [CNT_W-1:0]           count_q;
	logic                       ovf_q;
	logic [SUM_W-1:0]           sum_q;

	logic                       v_s1;
	logic                       last_s1;
	logic [rbl_pkg::SQ_W-1:0]   sq_s1;
	logic [CNT_W-1:0]           cnt_s1;
	logic                       ovf_s1;

	logic                       stall;
	logic                       accept;
	logic                       room;
	logic                       counted;
	logic [rbl_pkg::SAMPLE_W-1:0] raw;
	logic [rbl_pkg::SAMPLE_W-1:0] mag;
	logic [2*rbl_pkg::SAMPLE_W-1:0] square;
	logic [CNT_W-1:0]           count_nx;
	logic                       ovf_nx;
	logic [SUM_W-1:0]           sum_nx;

	// A closing item in stage one waits while the queue is full.
	assign stall       = v_s1 && last_s1 && q_stat.full;
	assign audio.ready = !stall;
	assign accept      = audio.valid && audio.ready;

	// Count and overflow decision for the item being accepted.
	always_comb begin
		raw      = audio.sample;
		mag      = raw[rbl_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
		square   = mag * mag;
		room     = count_q < MAX_CNT;
		counted  = audio.sample_valid && room;
		count_nx = count_q + CNT_W'(counted);
		ovf_nx   = ovf_q || (audio.sample_valid && !room);
	end

	// Block totals handed to the queue when the closing item leaves stage one.
	assign sum_nx   = sum_q + SUM_W'(sq_s1);
	assign push     = v_s1 && last_s1 && !q_stat.full;
	assign push_sum = sum_nx;
	assign push_cnt = cnt_s1;
	assign push_ovf = ovf_s1;

	// Count and overflow state, updated at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (audio.block_end) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_nx;
				ovf_q   <= ovf_nx;
			end
		end
	end

	// Stage one: the registered square and the block snapshot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			sq_s1   <= '0;
			cnt_s1  <= '0;
			ovf_s1  <= 1'b0;
		end else if (!stall) begin
			v_s1 <= accept;
			if (accept) begin
				last_s1 <= audio.block_end;
				sq_s1   <= counted ? square[rbl_pkg::SQ_W-1:0] : '0;
				cnt_s1  <= count_nx;
				ovf_s1  <= ovf_nx;
			end
		end
	end

	// Sum of squares, cleared as each block is handed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (v_s1 && !stall) begin
			sum_q <= last_s1 ? '0 : sum_nx;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rbl_queue.sv
// Two-entry queue of finished block totals between the front and back ends.
`default_nettype none

module rbl_queue #(
	parameter int W = 53
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [W-1:0]  din,
	input  wire logic          pop,
	output logic [W-1:0]       dout,
	output rbl_pkg::q_stat_t   stat
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   fill_q;

	assign dout       = entry_q[rd_ptr_q];
	assign stat.full  = fill_q == 2'd2;
	assign stat.empty = fill_q == 2'd0;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill level; callers never push when full or pop when empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rbl_back.sv
// Back end: divides each block sum by its count, takes the square root, holds the result.
`default_nettype none

module rbl_back #(
	parameter int CNT_W = 11,
	parameter int SUM_W = 41
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rbl_pkg::q_stat_t   q_stat,
	input  wire logic [SUM_W-1:0]   blk_sum,
	input  wire logic [CNT_W-1:0]   blk_cnt,
	input  wire logic               blk_ovf,
	output logic                    pop,
	rbl_out_if.source               level
);

	localparam int STEP_W = $clog2(SUM_W);
	localparam int RAD_W  = rbl_pkg::SQ_W;
	localparam int ROOT_W = RAD_W + 1;
	localparam logic [ROOT_W-1:0] SBIT_INIT = ROOT_W'(1) << (RAD_W - 1);

	typedef enum logic [1:0] {B_IDLE, B_DIV, B_SQRT, B_DONE} state_t;

	state_t                         state_q;
	logic [SUM_W-1:0]               quot_q;
	logic [CNT_W-1:0]               rem_q;
	logic [CNT_W-1:0]               div_q;
	logic [STEP_W-1:0]              step_q;
	logic [RAD_W-1:0]               srem_q;
	logic [ROOT_W-1:0]              root_q;
	logic [ROOT_W-1:0]              sbit_q;
	logic [rbl_pkg::LEVEL_W-1:0]    level_q;
	logic [rbl_pkg::BSAMP_W-1:0]    bsamp_q;
	logic                           ovf_q;
	logic                           out_valid_q;
	logic [rbl_pkg::LEVEL_W-1:0]    out_level_q;
	logic [rbl_pkg::BSAMP_W-1:0]    out_bsamp_q;
	logic                           out_ovf_q;

	logic [CNT_W:0]                 rem_sh;
	logic [CNT_W:0]                 rem_dif;
	logic                           q_bit;
	logic [CNT_W-1:0]               rem_nx;
	logic [SUM_W-1:0]               quot_nx;
	logic [ROOT_W-1:0]              trial;
	logic [ROOT_W-1:0]              srem_dif;
	logic                           take;
	logic [RAD_W-1:0]               srem_nx;
	logic [ROOT_W-1:0]              root_nx;
	logic [CNT_W+rbl_pkg::BSAMP_W-1:0] cnt_ext;

	assign pop = (state_q == B_IDLE) && !q_stat.empty;

	assign level.valid         = out_valid_q;
	assign level.rms_level     = out_level_q;
	assign level.block_samples = out_bsamp_q;
	assign level.overflow      = out_ovf_q;

	// One restoring division step and one square root step.
	always_comb begin
		rem_sh   = {rem_q, quot_q[SUM_W-1]};
		rem_dif  = rem_sh - {1'b0, div_q};
		q_bit    = rem_sh >= {1'b0, div_q};
		rem_nx   = q_bit ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		quot_nx  = {quot_q[SUM_W-2:0], q_bit};
		trial    = root_q + sbit_q;
		srem_dif = {1'b0, srem_q} - trial;
		take     = {1'b0, srem_q} >= trial;
		srem_nx  = take ? srem_dif[RAD_W-1:0] : srem_q;
		root_nx  = take ? ((root_q >> 1) + sbit_q) : (root_q >> 1);
		cnt_ext  = {{rbl_pkg::BSAMP_W{1'b0}}, blk_cnt};
	end

	// Sequencer: take a block, divide, root, then hand the result to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			quot_q      <= '0;
			rem_q       <= '0;
			div_q       <= '0;
			step_q      <= '0;
			srem_q      <= '0;
			root_q      <= '0;
			sbit_q      <= '0;
			level_q     <= '0;
			bsamp_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_level_q <= '0;
			out_bsamp_q <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			// The done state reloads the output register on its own.
			if (out_valid_q && level.ready && (state_q != B_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						quot_q  <= blk_sum;
						rem_q   <= '0;
						div_q   <= blk_cnt;
						step_q  <= STEP_W'(SUM_W - 1);
						bsamp_q <= cnt_ext[rbl_pkg::BSAMP_W-1:0];
						ovf_q   <= blk_ovf;
						srem_q  <= '0;
						root_q  <= '0;
						sbit_q  <= SBIT_INIT;
						// An empty block skips the division and roots zero.
						state_q <= (blk_cnt == '0) ? B_SQRT : B_DIV;
					end
				end
				B_DIV: begin
					quot_q <= quot_nx;
					rem_q  <= rem_nx;
					if (step_q == '0) begin
						// The mean of squares never exceeds 2^30.
						srem_q  <= quot_nx[RAD_W-1:0];
						state_q <= B_SQRT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				B_SQRT: begin
					srem_q <= srem_nx;
					root_q <= root_nx;
					sbit_q <= sbit_q >> 2;
					if (sbit_q[0]) begin
						level_q <= root_nx[rbl_pkg::LEVEL_W-1:0];
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (!out_valid_q || level.ready) begin
						out_valid_q <= 1'b1;
						out_level_q <= level_q;
						out_bsamp_q <= bsamp_q;
						out_ovf_q   <= ovf_q;
						state_q     <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rbl_checker.sv
// Port-level checks on the level channel of the block level meter, and their binding.
`default_nettype none

`include "rms_block_level_meter_defines.svh"

module rbl_checker #(
	parameter int MAX_BLOCK = rbl_pkg::MAX_BLOCK_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [rbl_pkg::LEVEL_W-1:0]   rms_level,
	input wire logic [rbl_pkg::BSAMP_W-1:0]   block_samples,
	input wire logic                          overflow
);

	localparam logic [rbl_pkg::LEVEL_W-1:0] LEVEL_TOP = 16'h8000;
	localparam logic [rbl_pkg::BSAMP_W-1:0] FULL_CNT =
		rbl_pkg::BSAMP_W'(MAX_BLOCK % (1 << rbl_pkg::BSAMP_W));

	// A result held back by the receiver stays offered and unchanged.
	`RBL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`RBL_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(rms_level) && $stable(block_samples) && $stable(overflow))

	// The level never exceeds full scale.
	`RBL_ASSERT_NOW(a_level_range, clk, arst_n, out_valid, rms_level <= LEVEL_TOP)

	// An empty block reports a zero level and no overflow.
	`RBL_ASSERT_NOW(a_empty_block, clk, arst_n, out_valid && (block_samples == '0) && (MAX_BLOCK < (1 << rbl_pkg::BSAMP_W)), (rms_level == '0) && !overflow)

	// Overflow is only reported for a block that reached the sample limit.
	`RBL_ASSERT_NOW(a_overflow_full, clk, arst_n, out_valid && overflow, block_samples == FULL_CNT)

endmodule

bind rms_block_level_meter rbl_checker #(
	.MAX_BLOCK (MAX_BLOCK)
) u_rbl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (level.valid),
	.out_ready     (level.ready),
	.rms_level     (level.rms_level),
	.block_samples (level.block_samples),
	.overflow      (level.overflow)
);

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench of the block RMS level meter: directed items, one long block, then random blocks.
`timescale 1ns / 1ps

module tb;

	localparam int MAX_BLOCK  = rbl_pkg::MAX_BLOCK_DEF;
	localparam int ITEM_GOAL  = 1550;
	localparam int DRAIN_WAIT = 120;

	// One result item: level, sample count and overflow flag.
	typedef struct packed {
		logic [rbl_pkg::LEVEL_W-1:0] lvl;
		logic [rbl_pkg::BSAMP_W-1:0] cnt;
		logic                        ovf;
	} level_t;

	// One directed row; want is used only where typed is set.
	typedef struct packed {
		logic [rbl_pkg::SAMPLE_W-1:0] smp;
		logic                         sv;
		logic                         be;
		logic                         typed;
		level_t                       want;
	} audio_row_t;

	localparam int N_ROWS = 19;

	audio_row_t directed_rows [N_ROWS] = '{
		'{16'h0000, 1'b0, 1'b1, 1'b1, '{16'd0, 11'd0, 1'b0}},
		'{16'h8000, 1'b1, 1'b1, 1'b1, '{16'd32768, 11'd1, 1'b0}},
		'{16'h7FFF, 1'b1, 1'b1, 1'b1, '{16'd32767, 11'd1, 1'b0}},
		'{16'h0000, 1'b1, 1'b1, 1'b1, '{16'd0, 11'd1, 1'b0}},
		'{16'h0001, 1'b1, 1'b1, 1'b1, '{16'd1, 11'd1, 1'b0}},
		'{16'hFFFF, 1'b1, 1'b1, 1'b1, '{16'd1, 11'd1, 1'b0}},
		'{16'h1234, 1'b0, 1'b1, 1'b1, '{16'd0, 11'd0, 1'b0}},
		'{16'h0003, 1'b1, 1'b0, 1'b0, '0},
		'{16'h0004, 1'b1, 1'b1, 1'b0, '0},
		'{16'h0064, 1'b1, 1'b0, 1'b0, '0},
		'{16'hFFF9, 1'b0, 1'b0, 1'b0, '0},
		'{16'hFF9C, 1'b1, 1'b1, 1'b1, '{16'd100, 11'd2, 1'b0}},
		'{16'h5555, 1'b1, 1'b0, 1'b0, '0},
		'{16'hAAAA, 1'b1, 1'b0, 1'b0, '0},
		'{16'h7FFF, 1'b0, 1'b1, 1'b0, '0},
		'{16'h8000, 1'b1, 1'b0, 1'b0, '0},
		'{16'h7FFF, 1'b1, 1'b1, 1'b0, '0},
		'{16'h0000, 1'b0, 1'b0, 1'b0, '0},
		'{16'h0000, 1'b0, 1'b1, 1'b1, '{16'd0, 11'd0, 1'b0}}
	};

	logic clk = 1'b0;
	logic arst_n;

	rbl_in_if  audio_ch ();
	rbl_out_if level_ch ();

	rms_block_level_meter #(
		.MAX_BLOCK(MAX_BLOCK)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.audio(audio_ch),
		.level(level_ch)
	);

	// Predictor state of the current block.
	logic [63:0] square_acc;
	int unsigned counted;
	bit          excess_seen;

	level_t pending_levels [$];
	level_t got_level;
	level_t want_level;
	int     fail_count;
	int     counted_items;
	bit     audio_idle;
	bit     level_idle;

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Integer square root, one result bit per step.
	function automatic logic [rbl_pkg::LEVEL_W-1:0] floor_root(input logic [63:0] x);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] probe;
		rem = x;
		root = '0;
		probe = 64'd1 << 32;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root[rbl_pkg::LEVEL_W-1:0];
	endfunction

	// Fold one accepted item into the block totals; returns 1 when it closes a block.
	function automatic bit meter_step(input logic [rbl_pkg::SAMPLE_W-1:0] smp, input bit sv,
		input bit be, output level_t res);
		logic [16:0] mag;
		res = '0;
		if (sv) begin
			if (counted < MAX_BLOCK) begin
				mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
				square_acc = square_acc + 64'(mag) * 64'(mag);
				counted++;
			end else begin
				excess_seen = 1'b1;
			end
		end
		if (!be)
			return 1'b0;
		res.lvl = (counted != 0) ? floor_root(square_acc / 64'(counted)) : '0;
		res.cnt = counted[rbl_pkg::BSAMP_W-1:0];
		res.ovf = excess_seen;
		square_acc = '0;
		counted = 0;
		excess_seen = 1'b0;
		return 1'b1;
	endfunction

	// Random sample: small magnitudes, extremes, or any 16-bit value.
	function automatic logic [rbl_pkg::SAMPLE_W-1:0] pick_sample();
		logic [rbl_pkg::SAMPLE_W-1:0] v;
		case ($urandom_range(0, 3))
			0: begin
				v = 16'($urandom_range(0, 255));
				if ($urandom_range(0, 1) == 1)
					v = ~v;
			end
			1: begin
				case ($urandom_range(0, 3))
					0: v = 16'h8000;
					1: v = 16'h7FFF;
					2: v = 16'hFFFF;
					default: v = 16'h0001;
				endcase
			end
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// Offer one audio item, wait for its acceptance and record the expected level.
	task automatic send_audio(input logic [rbl_pkg::SAMPLE_W-1:0] smp, input bit sv,
		input bit be, input bit typed, input level_t want);
		level_t pred;
		@(negedge clk);
		while (audio_idle && $urandom_range(0, 99) < 33) begin
			audio_ch.valid <= 1'b0;
			@(negedge clk);
		end
		audio_ch.valid        <= 1'b1;
		audio_ch.sample       <= smp;
		audio_ch.sample_valid <= sv;
		audio_ch.block_end    <= be;
		do
			@(posedge clk);
		while (!audio_ch.ready);
		counted_items++;
		if (meter_step(smp, sv, be, pred))
			pending_levels.push_back(typed ? want : pred);
	endtask

	// Level receiver stalls at random once out of reset, but not while level_idle is clear.
	always @(negedge clk) begin
		if (!arst_n)
			level_ch.ready <= 1'b0;
		else
			level_ch.ready <= level_idle ? ($urandom_range(0, 99) >= 33) : 1'b1;
	end

	// Compare each accepted level item with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && level_ch.valid && level_ch.ready) begin
			got_level = '{level_ch.rms_level, level_ch.block_samples, level_ch.overflow};
			if (pending_levels.size() == 0) begin
				$error("level item with no block pending: rms_level %0d block_samples %0d",
					got_level.lvl, got_level.cnt);
				fail_count++;
			end else begin
				want_level = pending_levels.pop_front();
				if (got_level.lvl !== want_level.lvl) begin
					$error("rms_level expected %0d got %0d", want_level.lvl, got_level.lvl);
					fail_count++;
				end
				if (got_level.cnt !== want_level.cnt) begin
					$error("block_samples expected %0d got %0d", want_level.cnt,
						got_level.cnt);
					fail_count++;
				end
				if (got_level.ovf !== want_level.ovf) begin
					$error("overflow expected %0d got %0d", want_level.ovf, got_level.ovf);
					fail_count++;
				end
			end
		end
	end

	// Hard limit on the run time.
	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Reset, directed rows, one long block, then short random blocks.
	initial begin
		int blk;
		int len;
		int n_long;
		int i;
		arst_n = 1'b0;
		audio_ch.valid = 1'b0;
		audio_ch.sample = '0;
		audio_ch.sample_valid = 1'b0;
		audio_ch.block_end = 1'b0;
		level_ch.ready = 1'b0;
		square_acc = '0;
		counted = 0;
		excess_seen = 1'b0;
		fail_count = 0;
		counted_items = 0;
		audio_idle = 1'b1;
		level_idle = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part.
		for (i = 0; i < N_ROWS; i++)
			send_audio(directed_rows[i].smp, directed_rows[i].sv, directed_rows[i].be,
				directed_rows[i].typed, directed_rows[i].want);

		// One block around MAX_BLOCK counted samples, with ignored items mixed in.
		n_long = MAX_BLOCK - 1 + int'($urandom_range(0, 3));
		i = 0;
		while (i < n_long) begin
			if ($urandom_range(0, 19) == 0) begin
				send_audio(pick_sample(), 1'b0, 1'b0, 1'b0, '0);
			end else begin
				send_audio(pick_sample(), 1'b1, 1'b0, 1'b0, '0);
				i++;
			end
		end
		send_audio(pick_sample(), 1'($urandom_range(0, 1)), 1'b1, 1'b0, '0);

		// Short blocks; a run of them goes without any idling on either side.
		blk = 0;
		while (counted_items < ITEM_GOAL) begin
			audio_idle = !(blk >= 15 && blk < 45);
			level_idle = audio_idle;
			case ($urandom_range(0, 9))
				0: len = 0;
				1, 2, 3, 4, 5: len = int'($urandom_range(1, 4));
				6, 7, 8: len = int'($urandom_range(5, 20));
				default: len = int'($urandom_range(21, 64));
			endcase
			for (i = 0; i < len; i++)
				send_audio(pick_sample(), $urandom_range(0, 9) != 0, 1'b0, 1'b0, '0);
			send_audio(pick_sample(), 1'($urandom_range(0, 1)), 1'b1, 1'b0, '0);
			blk++;
		end
		audio_idle = 1'b1;
		level_idle = 1'b1;
		@(negedge clk);
		audio_ch.valid <= 1'b0;

		// Drain the remaining levels, then allow for anything late.
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: rms_block_level_meter.f
+incdir+rtl/core
rtl/core/rbl_pkg.sv
rtl/core/rbl_if.sv
rtl/core/rbl_front.sv
rtl/core/rbl_queue.sv
rtl/core/rbl_back.sv
rtl/core/rms_block_level_meter.sv
rtl/core/rbl_checker.sv
sim/tb.sv
